FILE: rtl/core/lscst_pkg.sv
// Shared types and constants for the load short-circuit sweep test block.
`default_nettype none
package lscst_pkg;

  localparam int RAW_W   = 12;
  localparam int SCALE_W = 16;
  localparam int LVL_W   = 20;
  localparam int ACC_W   = 32;
  localparam int CNT_W   = 4;
  localparam int STEP_W  = 7;
  localparam int SUM_W   = 40;
  localparam int DIV_W   = 60;
  localparam int DCNT_W  = $clog2(DIV_W);
  localparam int CAUSE_W = 2;

  // Trip causes.
  localparam logic [CAUSE_W-1:0] CAUSE_NONE = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_PEAK = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_AVG  = 2'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_KNEE = 2'd3;

  // Register indexes.
  localparam logic [2:0] REG_VOLT_SCALE = 3'd0;
  localparam logic [2:0] REG_CURR_SCALE = 3'd1;
  localparam logic [2:0] REG_VOC        = 3'd2;
  localparam logic [2:0] REG_ABORT      = 3'd3;
  localparam logic [2:0] REG_TRIP       = 3'd4;

  typedef struct packed {
    logic       load;
    logic       sample;
    logic       mul;
    logic       div_start;
    logic       ex_wb;
    logic       i8_wb;
    logic       ema_first;
    logic       ema_wb;
    logic       upd;
    logic       knee;
    logic       fin;
  } lscst_cmd_t;

  typedef struct packed {
    logic need_step;
    logic div_done;
    logic step_zero;
    logic out_free;
  } lscst_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/lscst_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lscst_div
  import lscst_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [ACC_W-1:0] divisor,
  output logic                  done,
  output logic      [DIV_W-1:0] quotient
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [ACC_W-1:0]  rem;
  logic [ACC_W-1:0]  dvs;
  logic [DIV_W-1:0]  quo;
  logic [ACC_W:0]    rem_sh;
  logic              ge;

  // The dividend shifts out of the top of quo while quotient bits enter below.
  assign rem_sh   = {rem, quo[DIV_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIV_W - 1);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= ge ? ACC_W'(rem_sh - {1'b0, dvs}) : ACC_W'(rem_sh);
        quo <= {quo[DIV_W-2:0], ge};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/lscst_dp.sv
// Datapath: accumulators, per-step arithmetic, verdict and result register.
`default_nettype none
module lscst_dp
  import lscst_pkg::*;
#(
  parameter int SAMPLES_PER_STEP = 10,
  parameter int MAX_STEPS        = 75,
  parameter int KNEE_MIN_STEP    = 5
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lscst_cmd_t         cmd,
  output lscst_sts_t              sts,
  input  wire logic               in_req,
  input  wire logic [RAW_W-1:0]   in_v,
  input  wire logic [RAW_W-1:0]   in_i,
  input  wire logic [SCALE_W-1:0] volt_scale,
  input  wire logic [SCALE_W-1:0] current_scale,
  input  wire logic [LVL_W-1:0]   open_circuit_voltage,
  input  wire logic [LVL_W-1:0]   abort_current,
  input  wire logic [LVL_W-1:0]   trip_current,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [STEP_W-1:0]       out_duty,
  output logic                    out_done,
  output logic                    out_short,
  output logic [CAUSE_W-1:0]      out_cause,
  output logic                    out_enable
);

  localparam logic [CNT_W-1:0]  SPS_C     = CNT_W'(SAMPLES_PER_STEP);
  localparam logic [11:0]       LIM_K     = 12'(256 * SAMPLES_PER_STEP);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_STEPS - 1);
  localparam logic [STEP_W-1:0] KNEE_MIN  = STEP_W'(KNEE_MIN_STEP);
  // Reciprocals for the divisions by constants; both are exact over the operand ranges.
  localparam logic [36:0] STEP_RCP = 37'(((64'd1 << 36) + 64'(SAMPLES_PER_STEP) - 64'd1)
                                         / 64'(SAMPLES_PER_STEP));
  localparam logic [33:0] EMA_RCP  = 34'((64'd1 << 35) / 64'd3 + 64'd1);

  // Latched input transfer.
  logic             req_q;
  logic [RAW_W-1:0] v_q, i_q;

  // Test state.
  logic                    running;
  logic [STEP_W-1:0]       step_index;
  logic [CNT_W-1:0]        sample_count;
  logic [ACC_W-1:0]        vacc, iacc;
  logic [ACC_W-1:0]        ema;
  logic signed [SUM_W-1:0] delta_sum;
  logic [SUM_W-1:0]        extrap_sum;
  logic                    knee_flag;

  // Per-step work registers.
  logic [ACC_W-1:0]  iacc_s, vacc_s;
  logic [51:0]       num;
  logic              aborted, peak;
  logic [ACC_W-1:0]  i8;
  logic signed [33:0] delta;
  logic signed [47:0] prod_a;
  logic              ex5_gt;
  logic [34:0]       trip_x;
  logic [46:0]       sum100;
  logic [41:0]       lim;
  logic [STEP_W-1:0] count;
  logic              final_step;

  // Combinational helpers.
  logic [ACC_W-1:0]  vacc_new, iacc_new;
  logic [CNT_W-1:0]  cnt_new;
  logic [ACC_W-1:0]  abort_lim, trip_lim;
  logic [DIV_W-1:0]  dvd;
  logic [ACC_W-1:0]  dvs;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;
  logic [ACC_W-1:0]  ex_val;
  logic [68:0]       i8_prod;
  logic [33:0]       ema_sum;
  logic [67:0]       ema_prod;
  logic [ACC_W-1:0]  ema_q;
  logic [9:0]        step5;
  logic [STEP_W-1:0] count_c;
  logic              avg_trip;
  logic [CAUSE_W-1:0] cause;

  assign vacc_new  = vacc + ACC_W'(v_q * volt_scale);
  assign iacc_new  = iacc + ACC_W'(i_q * current_scale);
  assign cnt_new   = sample_count + 1'b1;
  assign abort_lim = ACC_W'(abort_current) * ACC_W'(LIM_K);
  assign trip_lim  = ACC_W'(trip_current) * ACC_W'(LIM_K);
  assign step5     = 10'(step_index) * 10'd5;
  assign count_c   = aborted ? step_index : step_index + 1'b1;

  assign sts.need_step = req_q && running && (cnt_new >= SPS_C);
  assign sts.div_done  = div_done;
  assign sts.step_zero = step_index == '0;
  assign sts.out_free  = !out_valid || out_ready;

  // Only the extrapolation needs a true division.
  assign dvd = {num, 8'b0};
  assign dvs = vacc_s;

  lscst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // Step average and one-third EMA by reciprocal multiplication.
  assign i8_prod  = 69'(iacc_s) * 69'(STEP_RCP);
  assign ema_sum  = 34'(i8) + 34'({ema, 1'b0});
  assign ema_prod = 68'(ema_sum) * 68'(EMA_RCP);
  assign ema_q    = ACC_W'(ema_prod >> 35);

  // Saturated extrapolated current; zero current gives zero even at zero voltage.
  always_comb begin
    if (num == '0) begin
      ex_val = '0;
    end else if (vacc_s == '0 || div_q[DIV_W-1:ACC_W] != '0) begin
      ex_val = '1;
    end else begin
      ex_val = div_q[ACC_W-1:0];
    end
  end

  always_comb begin
    if (count == '0) begin
      avg_trip = extrap_sum != '0;
    end else begin
      avg_trip = sum100 > 47'(lim);
    end
    priority if (aborted && peak) begin
      cause = CAUSE_PEAK;
    end else if (avg_trip) begin
      cause = CAUSE_AVG;
    end else if (knee_flag) begin
      cause = CAUSE_KNEE;
    end else begin
      cause = CAUSE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      step_index   <= '0;
      sample_count <= '0;
      vacc         <= '0;
      iacc         <= '0;
      ema          <= '0;
      delta_sum    <= '0;
      extrap_sum   <= '0;
      knee_flag    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        req_q <= in_req;
        v_q   <= in_v;
        i_q   <= in_i;
      end
      if (cmd.sample) begin
        if (!req_q) begin
          running      <= 1'b1;
          step_index   <= '0;
          sample_count <= '0;
          vacc         <= '0;
          iacc         <= '0;
          ema          <= '0;
          delta_sum    <= '0;
          extrap_sum   <= '0;
          knee_flag    <= 1'b0;
          out_valid    <= 1'b1;
          out_duty     <= '0;
          out_done     <= 1'b0;
          out_short    <= 1'b0;
          out_cause    <= CAUSE_NONE;
          out_enable   <= 1'b0;
        end else if (!running) begin
          out_valid  <= 1'b1;
          out_duty   <= '0;
          out_done   <= 1'b0;
          out_short  <= 1'b0;
          out_cause  <= CAUSE_NONE;
          out_enable <= 1'b0;
        end else if (sts.need_step) begin
          iacc_s       <= iacc_new;
          vacc_s       <= vacc_new;
          iacc         <= '0;
          vacc         <= '0;
          sample_count <= '0;
        end else begin
          iacc         <= iacc_new;
          vacc         <= vacc_new;
          sample_count <= cnt_new;
          out_valid    <= 1'b1;
          out_duty     <= step_index;
          out_done     <= 1'b0;
          out_short    <= 1'b0;
          out_cause    <= CAUSE_NONE;
          out_enable   <= 1'b0;
        end
      end
      if (cmd.mul) begin
        num     <= 52'(open_circuit_voltage) * 52'(iacc_s);
        aborted <= iacc_s > abort_lim;
        peak    <= iacc_s > trip_lim;
      end
      if (cmd.ex_wb) begin
        extrap_sum <= extrap_sum + SUM_W'(ex_val);
        ex5_gt     <= (35'(ex_val) * 35'd5) > (35'(trip_current) * 35'd1536);
      end
      if (cmd.i8_wb) begin
        i8 <= ACC_W'(i8_prod >> 36);
      end
      if (cmd.ema_first) begin
        ema   <= i8;
        delta <= '0;
      end
      if (cmd.ema_wb) begin
        ema   <= ema_q;
        delta <= signed'({2'b0, ema_q}) - signed'({2'b0, ema});
      end
      if (cmd.upd) begin
        if (!aborted) begin
          delta_sum <= delta_sum + SUM_W'(delta);
        end
        prod_a <= 48'(delta) * 48'(signed'({1'b0, step5}));
        trip_x <= 35'(trip_current) * 35'd21760;
      end
      if (cmd.knee) begin
        if (!aborted && step_index > KNEE_MIN && ex5_gt &&
            prod_a > 48'(delta_sum) * 48'sd6) begin
          knee_flag <= 1'b1;
        end
        count      <= count_c;
        sum100     <= 47'(extrap_sum) * 47'd100;
        lim        <= 42'(trip_x) * 42'(count_c);
        final_step <= aborted || step_index >= STEP_LAST;
      end
      if (cmd.fin) begin
        out_valid <= 1'b1;
        if (final_step) begin
          running    <= 1'b0;
          out_duty   <= '0;
          out_done   <= 1'b1;
          out_short  <= cause != CAUSE_NONE;
          out_cause  <= cause;
          out_enable <= cause == CAUSE_NONE;
        end else begin
          step_index <= step_index + 1'b1;
          out_duty   <= step_index + 1'b1;
          out_done   <= 1'b0;
          out_short  <= 1'b0;
          out_cause  <= CAUSE_NONE;
          out_enable <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/lscst_ctrl.sv
// Controller: sequences one input transfer through the datapath.
`default_nettype none
module lscst_ctrl
  import lscst_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire lscst_sts_t sts,
  output lscst_cmd_t      cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SAMPLE   = 4'd1;
  localparam logic [3:0] ST_MUL      = 4'd2;
  localparam logic [3:0] ST_EX_GO    = 4'd3;
  localparam logic [3:0] ST_EX_WAIT  = 4'd4;
  localparam logic [3:0] ST_I8_GO    = 4'd5;
  localparam logic [3:0] ST_EMA_GO   = 4'd6;
  localparam logic [3:0] ST_UPD      = 4'd7;
  localparam logic [3:0] ST_KNEE     = 4'd8;
  localparam logic [3:0] ST_FIN      = 4'd9;

  logic [3:0] state, state_next;

  assign in_ready = (state == ST_IDLE) && sts.out_free;

  always_comb begin
    cmd        = '0;
    cmd.load   = in_valid && in_ready;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_next = ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        cmd.sample = 1'b1;
        state_next = sts.need_step ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_EX_GO;
      end
      ST_EX_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_EX_WAIT;
      end
      ST_EX_WAIT: begin
        if (sts.div_done) begin
          cmd.ex_wb  = 1'b1;
          state_next = ST_I8_GO;
        end
      end
      ST_I8_GO: begin
        cmd.i8_wb  = 1'b1;
        state_next = ST_EMA_GO;
      end
      ST_EMA_GO: begin
        if (sts.step_zero) begin
          cmd.ema_first = 1'b1;
        end else begin
          cmd.ema_wb = 1'b1;
        end
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = ST_KNEE;
      end
      ST_KNEE: begin
        cmd.knee   = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin    = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/load_short_circuit_sweep_test_top.sv
// Top level of the load short-circuit ramp test: register file, controller, datapath.
// A start request, an idle sample or a sample inside a step has its result registered in the
// cycle after the transfer; a sample that closes a step passes through the multiply, the
// bit-serial extrapolation divide, the step average, the EMA, the update and the knee test.
// One transfer at a time: a new one is taken only once control is idle and the result is free.
// Reset (rst, synchronous, active high) restores the register defaults and clears the test state.
`default_nettype none
module load_short_circuit_sweep_test_top
  import lscst_pkg::*;
#(
  parameter int SAMPLES_PER_STEP = 10,
  parameter int MAX_STEPS        = 75,
  parameter int KNEE_MIN_STEP    = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // v_sample[11:0], i_sample[23:12]
  input  wire logic [0:0]  s_tuser,   // req_type[0]
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // duty_percent[6:0], short_found[7], trip_cause[9:8],
                                      // enable_output[10], zero[15:11]
  output logic             m_tlast,   // test_done
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [SCALE_W-1:0] volt_scale, current_scale;
  logic [LVL_W-1:0]   open_circuit_voltage, abort_current, trip_current;
  logic [2:0]         reg_idx;
  logic               wr_en;

  lscst_cmd_t         cmd;
  lscst_sts_t         sts;
  logic [STEP_W-1:0]  duty;
  logic               short_found, enable_output;
  logic [CAUSE_W-1:0] trip_cause;

  // The register index is the word address; writes beyond the list fall through.
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_scale           <= SCALE_W'(256);
      current_scale        <= SCALE_W'(256);
      open_circuit_voltage <= '0;
      abort_current        <= '0;
      trip_current         <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_VOLT_SCALE: volt_scale           <= pwdata[SCALE_W-1:0];
        REG_CURR_SCALE: current_scale        <= pwdata[SCALE_W-1:0];
        REG_VOC:        open_circuit_voltage <= pwdata[LVL_W-1:0];
        REG_ABORT:      abort_current        <= pwdata[LVL_W-1:0];
        REG_TRIP:       trip_current         <= pwdata[LVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_VOLT_SCALE: prdata = 32'(volt_scale);
      REG_CURR_SCALE: prdata = 32'(current_scale);
      REG_VOC:        prdata = 32'(open_circuit_voltage);
      REG_ABORT:      prdata = 32'(abort_current);
      REG_TRIP:       prdata = 32'(trip_current);
      default:        prdata = '0;
    endcase
  end

  // The controller walks each transfer through the datapath; the datapath owns
  // the result register, so a finished result may wait while control goes idle.
  lscst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lscst_dp #(
    .SAMPLES_PER_STEP (SAMPLES_PER_STEP),
    .MAX_STEPS        (MAX_STEPS),
    .KNEE_MIN_STEP    (KNEE_MIN_STEP)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_req               (s_tuser[0]),
    .in_v                 (s_tdata[11:0]),
    .in_i                 (s_tdata[23:12]),
    .volt_scale           (volt_scale),
    .current_scale        (current_scale),
    .open_circuit_voltage (open_circuit_voltage),
    .abort_current        (abort_current),
    .trip_current         (trip_current),
    .out_ready            (m_tready),
    .out_valid            (m_tvalid),
    .out_duty             (duty),
    .out_done             (m_tlast),
    .out_short            (short_found),
    .out_cause            (trip_cause),
    .out_enable           (enable_output)
  );

  assign m_tdata = {5'b0, enable_output, trip_cause, short_found, duty};

endmodule
`default_nettype wire

FILE: rtl/core/lscst_chk.sv
// Port-level checker for the sweep test top level, with its bind.
`default_nettype none
module lscst_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tlast
);

  // A waiting result is not withdrawn.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  // One transfer at a time: the block is busy in the cycle after a transfer.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while previous transfer in work");

  // The result that ends the test drives zero duty.
  a_done_duty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[6:0] == 7'd0)
    else $error("nonzero duty on final result");

  // Verdict fields stay zero until the test ends.
  a_no_verdict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[10:7] == 4'd0)
    else $error("verdict fields set before test end");

  // The load enable is the inverse of the short verdict.
  a_enable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[10] != m_tdata[7])
    else $error("enable does not match verdict");

endmodule

bind load_short_circuit_sweep_test_top lscst_chk u_lscst_chk (.*);
`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the load short-circuit sweep test block.
`timescale 1ns / 1ps
module tb;
  import lscst_pkg::*;

  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;
  localparam int STEP_SAMPLES = 10;
  localparam int LAST_STEP    = 75;
  localparam int KNEE_FROM    = 5;
  localparam longint unsigned EXTRAP_SAT = 64'hFFFF_FFFF;

  // One expected result, in the order of the block's output fields.
  typedef struct packed {
    logic [6:0] duty;
    logic       done;
    logic       shorted;
    logic [1:0] cause;
    logic       enable;
  } sweep_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // v_sample[11:0], i_sample[23:12]
  logic [0:0]  s_tuser = '0;  // req_type[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;       // duty[6:0], short[7], cause[9:8], enable[10], zero[15:11]
  logic        m_tlast;       // test_done
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  load_short_circuit_sweep_test_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Predictor copy of the registers and of the sweep state.
  longint unsigned vscale = 256, iscale = 256, voc = 0, abort_lim = 0, trip_lim = 0;
  logic            sweeping = 1'b0;
  longint unsigned step_no = 0, nsamp = 0, vsum = 0, isum = 0, ema = 0, extrap_total = 0;
  longint          delta_total = 0;
  logic            knee_seen = 1'b0;

  sweep_result_t expected_results[$];
  int errors = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sweeps_ended = 0;
  int cause_hits[4] = '{0, 0, 0, 0};

  task automatic report(input string msg);
    errors++;
    if (errors <= 40) $display("tb: mismatch at %0t: %s", $realtime, msg);
  endtask

  // Works out the result of one accepted transfer and queues it.
  task automatic predict_sweep(input logic req, input logic [11:0] v, input logic [11:0] i);
    longint unsigned iacc, vacc, ex, i8, cnt, num, nxt;
    longint          dl;
    logic            ab, pk, av;
    logic [1:0]      cz;
    sweep_result_t   r;
    r = '0;
    dl = 0;
    if (req == REQ_START) begin
      sweeping = 1'b1; step_no = 0; nsamp = 0; vsum = 0; isum = 0;
      ema = 0; extrap_total = 0; delta_total = 0; knee_seen = 1'b0;
    end else if (sweeping) begin
      vsum += longint'(v) * vscale;
      isum += longint'(i) * iscale;
      nsamp++;
      if (nsamp < STEP_SAMPLES) begin
        r.duty = step_no[6:0];
      end else begin
        iacc = isum; vacc = vsum; isum = 0; vsum = 0; nsamp = 0;
        num = voc * iacc;
        if (num == 0) ex = 0;
        else if (vacc == 0) ex = EXTRAP_SAT;
        else begin
          ex = (num << 8) / vacc;
          if (ex > EXTRAP_SAT) ex = EXTRAP_SAT;
        end
        extrap_total += ex;
        i8 = iacc / STEP_SAMPLES;
        if (step_no == 0) ema = i8;
        else begin
          nxt = (i8 + 2 * ema) / 3;
          dl = longint'(nxt) - longint'(ema);
          ema = nxt;
        end
        ab = iacc > abort_lim * 256 * STEP_SAMPLES;
        if (!ab) begin
          delta_total += dl;
          // The knee needs a late step, a delta well above its running mean
          // and an extrapolated current well above the limit.
          if (step_no > KNEE_FROM && dl * 5 * longint'(step_no) > delta_total * 6 &&
              5 * ex > 6 * 256 * trip_lim)
            knee_seen = 1'b1;
        end
        if (ab || step_no + 1 >= LAST_STEP) begin
          cnt = ab ? step_no : step_no + 1;
          pk = ab && iacc > trip_lim * 256 * STEP_SAMPLES;
          if (cnt == 0) av = extrap_total != 0;
          else av = 100 * extrap_total > 85 * 256 * trip_lim * cnt;
          if (pk) cz = CAUSE_PEAK;
          else if (av) cz = CAUSE_AVG;
          else if (knee_seen) cz = CAUSE_KNEE;
          else cz = CAUSE_NONE;
          sweeping = 1'b0;
          r.done = 1'b1;
          r.shorted = cz != CAUSE_NONE;
          r.cause = cz;
          r.enable = cz == CAUSE_NONE;
          sweeps_ended++;
          cause_hits[cz]++;
        end else begin
          step_no++;
          r.duty = step_no[6:0];
        end
      end
    end
    expected_results.push_back(r);
  endtask

  // Sends one item, with a random gap in front of it, and predicts it once taken.
  task automatic send_item(input logic req, input logic [11:0] v, input logic [11:0] i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {i, v};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_sweep(req, v, i);
    items_sent++;
  endtask

  // Lowers the valid and holds off until every expected result has arrived.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_VOLT_SCALE: vscale = value[15:0];
      REG_CURR_SCALE: iscale = value[15:0];
      REG_VOC:        voc = value[19:0];
      REG_ABORT:      abort_lim = value[19:0];
      REG_TRIP:       trip_lim = value[19:0];
      default: ;
    endcase
  endtask

  task automatic send_step(input logic [11:0] v, input logic [11:0] i);
    repeat (STEP_SAMPLES) send_item(REQ_SAMPLE, v, i);
  endtask

  // Directed: defaults, idle samples, restart, first-step abort, zero voltage.
  task automatic test_directed();
    send_item(REQ_SAMPLE, 12'hFFF, 12'hFFF);   // ignored while idle
    send_item(REQ_START, 12'h000, 12'h000);
    send_step(12'h000, 12'h000);               // zero current, no abort
    send_item(REQ_START, 12'hFFF, 12'hFFF);    // restart while running
    send_step(12'hFFF, 12'hFFF);               // aborts on the first step with a peak
    drain_results();
    write_reg(REG_VOLT_SCALE, 32'h0000_FFFF);
    write_reg(REG_CURR_SCALE, 32'h0000_FFFF);
    write_reg(REG_VOC, 32'h000F_FFFF);
    write_reg(REG_ABORT, 32'h0000_0000);
    write_reg(REG_TRIP, 32'h000F_FFFF);
    // Zero voltage saturates the extrapolation; the first-step abort then
    // trips the average test with no counted steps.
    send_item(REQ_START, 12'h000, 12'h000);
    send_step(12'h000, 12'h001);
    drain_results();
  endtask

  task automatic random_config();
    write_reg(REG_VOLT_SCALE, $urandom_range(1) ? 32'd256 : $urandom_range(65535));
    write_reg(REG_CURR_SCALE, $urandom_range(1) ? 32'd256 : $urandom_range(65535));
    write_reg(REG_VOC, $urandom_range(3) == 0 ? $urandom_range(20'hFFFFF)
                                              : $urandom_range(1000, 5000));
    write_reg(REG_ABORT, $urandom_range(1) ? 32'h000F_FFFF : $urandom_range(300, 4095));
    write_reg(REG_TRIP, $urandom_range(4) == 0 ? $urandom_range(20'hFFFFF)
                                               : $urandom_range(0, 3000));
  endtask

  // One sweep of a few steps: a current ramp that may bend upward early on.
  // A sweep that is still running is restarted by the next one.
  task automatic run_ramp();
    int base, slope, bend_at, bend, cur, guard;
    base = $urandom_range(0, 200);
    slope = $urandom_range(0, 40);
    bend_at = $urandom_range(3, 8);
    bend = $urandom_range(0, 20);
    guard = 0;
    if ($urandom_range(9) == 0) drain_results();
    send_item(REQ_START, 12'($urandom), 12'($urandom));
    while (sweeping && guard < 10) begin
      cur = base + slope * int'(step_no);
      if (int'(step_no) > bend_at) cur += bend * (int'(step_no) - bend_at) ** 2;
      if (cur > 4000) cur = 4000;
      repeat (STEP_SAMPLES) begin
        if (sweeping)
          send_item(REQ_SAMPLE, 12'($urandom_range(2500, 4095)),
                    12'(cur + $urandom_range(0, 95)));
      end
      if ($urandom_range(49) == 0) send_item(1'($urandom), 12'($urandom), 12'($urandom));
      guard++;
    end
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct, input int quota);
    int stop_at;
    drain_results();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    random_config();
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 8) run_ramp();
      else repeat (10) send_item(1'($urandom), 12'($urandom), 12'($urandom));
    end
  endtask

  // The receiver stalls at random at the current rate.
  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    sweep_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result %h last %b", m_tdata, m_tlast));
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[6:0] != want.duty)
          report($sformatf("duty %0d, want %0d", m_tdata[6:0], want.duty));
        if (m_tlast != want.done)
          report($sformatf("test_done %b, want %b", m_tlast, want.done));
        if (m_tdata[7] != want.shorted)
          report($sformatf("short_found %b, want %b", m_tdata[7], want.shorted));
        if (m_tdata[9:8] != want.cause)
          report($sformatf("trip_cause %0d, want %0d", m_tdata[9:8], want.cause));
        if (m_tdata[10] != want.enable)
          report($sformatf("enable_output %b, want %b", m_tdata[10], want.enable));
        if (m_tdata[15:11] != 5'd0)
          report($sformatf("padding bits %b not zero", m_tdata[15:11]));
      end
    end
  end

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 9;
    recv_idle_pct = 50;
    test_directed();
    test_random_phase(9, 50, 150);
    test_random_phase(50, 9, 150);
    test_random_phase(0, 0, 150);
    s_tvalid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0)
      report($sformatf("%0d results never arrived", expected_results.size()));
    repeat (250) @(posedge clk);
    $display("tb: %0d items sent, %0d sweeps ended", items_sent, sweeps_ended);
    $display("tb: verdicts none %0d, peak %0d, average %0d, knee %0d",
             cause_hits[0], cause_hits[1], cause_hits[2], cause_hits[3]);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule
